### hdl/assert_macros.svh
// Assertion macros for the checker module of the drive and steer controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge while reset is released.
`define SDSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SDSC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/sdsc_pkg.sv
// Package with types and constants of the serial drive and steer controller.
package sdsc_pkg;

	localparam int SENSOR_BITS = 10;

	localparam logic [7:0] BYTE_QUERY = 8'd63;
	localparam logic [7:0] BYTE_ZERO  = 8'd48;
	localparam logic [7:0] CMD_COUNT  = 8'd6;

	localparam logic [7:0] RESET_TURN_SHORT  = 8'd60;
	localparam logic [7:0] RESET_TURN_LONG   = 8'd120;
	localparam logic [7:0] RESET_CENTER_TMO  = 8'd60;
	localparam logic [9:0] RESET_CENTER_THR  = 10'd1;

	typedef enum logic [1:0] {
		POS_LEFT   = 2'd0,
		POS_CENTER = 2'd1,
		POS_RIGHT  = 2'd2
	} pos_t;

	typedef enum logic [2:0] {
		CMD_STOP     = 3'd0,
		CMD_FORWARD  = 3'd1,
		CMD_BACKWARD = 3'd2,
		CMD_CENTER   = 3'd3,
		CMD_RIGHT    = 3'd4,
		CMD_LEFT     = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		REG_TURN_SHORT = 2'd0,
		REG_TURN_LONG  = 2'd1,
		REG_CENTER_TMO = 2'd2,
		REG_CENTER_THR = 2'd3
	} reg_idx_t;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] cmd_byte;
		logic [9:0] center_sample;
	} item_t;

	typedef struct packed {
		logic       fwd_drive_n;
		logic       bwd_drive_n;
		logic       steer_left_n;
		logic       steer_right_n;
		logic [1:0] steer_position;
		logic       ident_reply;
		logic       busy_reject;
	} result_t;

endpackage

### hdl/sdsc_ifs.sv
// Valid/ready channel interfaces for input items and result items.
interface sdsc_req_if;
	logic                 valid;
	logic                 ready;
	sdsc_pkg::item_t      data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sdsc_rsp_if;
	logic                 valid;
	logic                 ready;
	sdsc_pkg::result_t    data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/serial_drive_and_steer_controller.sv
// Drive and steering controller for a serial command stream and a millisecond tick.
// Each transaction on req is a command byte or a tick with a centering sensor sample, and it
// yields exactly one transaction on rsp with the drive and steering line levels, the recorded
// steering position and the identify and busy flags. An item passes an input register and
// then the result register, from which its result is offered on rsp; one item is taken
// every cycle as long as rsp is not stalled, and the state update between the two
// registers is a few compares and one 8-bit increment. The user is to write registers
// through cfg_we, cfg_index and cfg_data only while no transaction is in flight; the
// block itself does not enforce this.
module serial_drive_and_steer_controller (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [9:0]       cfg_data,
	sdsc_req_if.sink         req,
	sdsc_rsp_if.source       rsp
);

	logic [7:0] turn_short_q;
	logic [7:0] turn_long_q;
	logic [7:0] center_tmo_q;
	logic [9:0] center_thr_q;

	logic              valid_s1;
	sdsc_pkg::item_t   item_s1;
	logic              valid_s2;
	sdsc_pkg::result_t result_s2;

	logic              fwd_q, bwd_q, left_q, right_q;
	sdsc_pkg::pos_t    pos_q, target_q;
	logic              active_q, seek_q;
	logic [7:0]        ticks_q, limit_q;

	logic              fwd_d, bwd_d, left_d, right_d;
	sdsc_pkg::pos_t    pos_d, target_d;
	logic              active_d, seek_d;
	logic [7:0]        ticks_d, limit_d;
	logic              ident_d, busy_d;

	logic              advance;
	logic [7:0]        ticks_inc;
	logic [7:0]        byte_off;
	logic              is_cmd;
	logic [9:0]        sample;
	sdsc_pkg::cmd_t    cmd;

	assign advance   = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || advance;
	assign rsp.valid = valid_s2;
	assign rsp.data  = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_short_q <= sdsc_pkg::RESET_TURN_SHORT;
			turn_long_q  <= sdsc_pkg::RESET_TURN_LONG;
			center_tmo_q <= sdsc_pkg::RESET_CENTER_TMO;
			center_thr_q <= sdsc_pkg::RESET_CENTER_THR;
		end else if (cfg_we) begin
			unique case (sdsc_pkg::reg_idx_t'(cfg_index))
				sdsc_pkg::REG_TURN_SHORT: turn_short_q <= cfg_data[7:0];
				sdsc_pkg::REG_TURN_LONG:  turn_long_q  <= cfg_data[7:0];
				sdsc_pkg::REG_CENTER_TMO: center_tmo_q <= cfg_data[7:0];
				sdsc_pkg::REG_CENTER_THR: center_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign byte_off  = item_s1.cmd_byte - sdsc_pkg::BYTE_ZERO;
	assign is_cmd    = byte_off < sdsc_pkg::CMD_COUNT;
	assign cmd       = sdsc_pkg::cmd_t'(byte_off[2:0]);
	assign sample    = 10'(item_s1.center_sample[sdsc_pkg::SENSOR_BITS-1:0]);
	assign ticks_inc = ticks_q + 8'd1;

	always_comb begin
		fwd_d    = fwd_q;
		bwd_d    = bwd_q;
		left_d   = left_q;
		right_d  = right_q;
		pos_d    = pos_q;
		target_d = target_q;
		active_d = active_q;
		seek_d   = seek_q;
		ticks_d  = ticks_q;
		limit_d  = limit_q;
		ident_d  = 1'b0;
		busy_d   = 1'b0;
		if (item_s1.op == sdsc_pkg::OP_TICK) begin
			if (active_q) begin
				if (seek_q && sample <= center_thr_q) begin
					left_d   = 1'b1;
					right_d  = 1'b1;
					pos_d    = target_q;
					active_d = 1'b0;
					seek_d   = 1'b0;
				end else begin
					ticks_d = ticks_inc;
					if (ticks_inc == 8'd0 || ticks_inc >= limit_q) begin
						left_d   = 1'b1;
						right_d  = 1'b1;
						pos_d    = target_q;
						active_d = 1'b0;
						seek_d   = 1'b0;
					end
				end
			end
		end else if (item_s1.cmd_byte == sdsc_pkg::BYTE_QUERY) begin
			ident_d = 1'b1;
		end else if (is_cmd) begin
			if (active_q) begin
				busy_d = 1'b1;
			end else begin
				unique case (cmd)
					sdsc_pkg::CMD_STOP: begin
						fwd_d   = 1'b1;
						bwd_d   = 1'b1;
						left_d  = 1'b1;
						right_d = 1'b1;
					end
					sdsc_pkg::CMD_FORWARD: begin
						fwd_d = 1'b0;
						bwd_d = 1'b1;
					end
					sdsc_pkg::CMD_BACKWARD: begin
						fwd_d = 1'b1;
						bwd_d = 1'b0;
					end
					sdsc_pkg::CMD_CENTER: begin
						if (pos_q == sdsc_pkg::POS_LEFT || pos_q == sdsc_pkg::POS_RIGHT) begin
							if (pos_q == sdsc_pkg::POS_LEFT) begin
								right_d = 1'b0;
							end else begin
								left_d = 1'b0;
							end
							target_d = sdsc_pkg::POS_CENTER;
							limit_d  = center_tmo_q;
							ticks_d  = 8'd0;
							seek_d   = 1'b1;
							active_d = 1'b1;
						end
					end
					sdsc_pkg::CMD_RIGHT: begin
						if (pos_q != sdsc_pkg::POS_RIGHT) begin
							right_d  = 1'b0;
							target_d = sdsc_pkg::POS_RIGHT;
							limit_d  = (pos_q == sdsc_pkg::POS_CENTER) ? turn_short_q
								: turn_long_q;
							ticks_d  = 8'd0;
							seek_d   = 1'b0;
							active_d = 1'b1;
						end
					end
					sdsc_pkg::CMD_LEFT: begin
						if (pos_q != sdsc_pkg::POS_LEFT) begin
							left_d   = 1'b0;
							target_d = sdsc_pkg::POS_LEFT;
							limit_d  = (pos_q == sdsc_pkg::POS_CENTER) ? turn_short_q
								: turn_long_q;
							ticks_d  = 8'd0;
							seek_d   = 1'b0;
							active_d = 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			fwd_q    <= 1'b1;
			bwd_q    <= 1'b1;
			left_q   <= 1'b1;
			right_q  <= 1'b1;
			pos_q    <= sdsc_pkg::POS_CENTER;
			target_q <= sdsc_pkg::POS_CENTER;
			active_q <= 1'b0;
			seek_q   <= 1'b0;
			ticks_q  <= 8'd0;
			limit_q  <= 8'd0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (valid_s1 && advance) begin
				fwd_q    <= fwd_d;
				bwd_q    <= bwd_d;
				left_q   <= left_d;
				right_q  <= right_d;
				pos_q    <= pos_d;
				target_q <= target_d;
				active_q <= active_d;
				seek_q   <= seek_d;
				ticks_q  <= ticks_d;
				limit_q  <= limit_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.data;
		end
		if (valid_s1 && advance) begin
			result_s2.fwd_drive_n    <= fwd_d;
			result_s2.bwd_drive_n    <= bwd_d;
			result_s2.steer_left_n   <= left_d;
			result_s2.steer_right_n  <= right_d;
			result_s2.steer_position <= pos_d;
			result_s2.ident_reply    <= ident_d;
			result_s2.busy_reject    <= busy_d;
		end
	end

endmodule

### hdl/sdsc_checker.sv
// Port-level checker for the drive and steer controller, bound to its top level.
`include "assert_macros.svh"

module sdsc_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  sdsc_pkg::result_t rsp_data
);

	`SDSC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result changed while stalled")
	`SDSC_ASSERT(a_flags_excl, rsp_valid |-> !(rsp_data.ident_reply && rsp_data.busy_reject), "identify and busy both set")
	`SDSC_ASSERT(a_one_steer, rsp_valid |-> (rsp_data.steer_left_n || rsp_data.steer_right_n), "both steering lines active")
	`SDSC_ASSERT(a_busy_pulse, rsp_valid && rsp_data.busy_reject |-> (!rsp_data.steer_left_n || !rsp_data.steer_right_n), "busy reported with no pulse running")
	`SDSC_ASSERT_ALWAYS(a_pos_legal, rsp_valid |-> rsp_data.steer_position != 2'd3, "illegal steering position")

endmodule

bind serial_drive_and_steer_controller sdsc_checker u_sdsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
